/* rtl/core/hdc_pkg.sv */
// shared types and constants of the haptic detent controller
package hdc_pkg;

  localparam int ANGLE_W     = 24;
  localparam int DRIVE_W     = 16;
  localparam int INDEX_W     = 32;
  localparam int CENTRE_W    = 26;
  localparam int ERR_W       = 28;
  localparam int MAG_W       = 27;
  localparam int GAIN_W      = 16;
  localparam int LIMIT_W     = 15;
  localparam int DCOUNT_W    = 4;
  localparam int DEAD_DEG_W  = 4;
  localparam int SPAN_W      = 16;
  localparam int DEAD_W      = 12;
  localparam int LOCK_W      = 8;
  localparam int PROD_W      = GAIN_W + MAG_W;
  localparam int SCALED_W    = 25;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 2;

  // detent count limits and register reset values
  localparam int DCOUNT_MIN     = 3;
  localparam int DCOUNT_MAX     = 12;
  localparam int DCOUNT_RESET   = 12;
  localparam int GAIN_RESET     = 3200;
  localparam int LIMIT_RESET    = 1100;
  localparam int DEAD_DEG_RESET = 2;

  // snap threshold is 13/20 of the detent width
  localparam int SNAP_NUM     = 13;
  localparam int SNAP_DEN     = 20;
  localparam int DEG_PER_TURN = 360;

  // gain is in thousandths; divide by 1000 as multiply by ceil(2^35/1000)
  localparam int                  DIV_BASE   = 1000;
  localparam int                  DIV_SHIFT  = 35;
  localparam int                  DIV_MULT_W = 26;
  localparam logic [DIV_MULT_W-1:0] DIV_MULT = 26'd34359739;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_DETENT_COUNT = 2'd0,
    CFG_GAIN         = 2'd1,
    CFG_DRIVE_LIMIT  = 2'd2,
    CFG_DEAD_ZONE    = 2'd3
  } cfg_index_t;

  // working configuration seen by the datapath
  typedef struct packed {
    logic [SPAN_W-1:0]   span;
    logic [SPAN_W-1:0]   snap;
    logic [DEAD_W-1:0]   dead;
    logic [GAIN_W-1:0]   gain;
    logic [LIMIT_W-1:0]  limit;
    logic [SCALED_W-1:0] limit_scaled;
  } cfg_t;

  typedef struct packed {
    logic               capture;
    logic [ANGLE_W-1:0] angle;
  } sample_t;

  typedef struct packed {
    logic               capture;
    logic               neg;
    logic [MAG_W-1:0]   mag;
    logic [INDEX_W-1:0] index;
  } track_t;

endpackage

/* rtl/core/hdc_cfg.sv */
// configuration registers and detent geometry lookup
module hdc_cfg import hdc_pkg::*; #(
  parameter int UNITS_PER_TURN = 6283
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   we,
  input  logic [CFG_INDEX_W-1:0] index,
  input  logic [CFG_DATA_W-1:0]  data,
  output cfg_t                   cfg
);

  // detent width per detent count, out-of-range counts folded to the ends
  localparam logic [SPAN_W-1:0] SPAN_LUT [16] = '{
    SPAN_W'(UNITS_PER_TURN / 3),  SPAN_W'(UNITS_PER_TURN / 3),
    SPAN_W'(UNITS_PER_TURN / 3),  SPAN_W'(UNITS_PER_TURN / 3),
    SPAN_W'(UNITS_PER_TURN / 4),  SPAN_W'(UNITS_PER_TURN / 5),
    SPAN_W'(UNITS_PER_TURN / 6),  SPAN_W'(UNITS_PER_TURN / 7),
    SPAN_W'(UNITS_PER_TURN / 8),  SPAN_W'(UNITS_PER_TURN / 9),
    SPAN_W'(UNITS_PER_TURN / 10), SPAN_W'(UNITS_PER_TURN / 11),
    SPAN_W'(UNITS_PER_TURN / 12), SPAN_W'(UNITS_PER_TURN / 12),
    SPAN_W'(UNITS_PER_TURN / 12), SPAN_W'(UNITS_PER_TURN / 12)
  };

  localparam logic [SPAN_W-1:0] SNAP_LUT [16] = '{
    SPAN_W'((UNITS_PER_TURN / 3) * SNAP_NUM / SNAP_DEN),
    SPAN_W'((UNITS_PER_TURN / 3) * SNAP_NUM / SNAP_DEN),
    SPAN_W'((UNITS_PER_TURN / 3) * SNAP_NUM / SNAP_DEN),
    SPAN_W'((UNITS_PER_TURN / 3) * SNAP_NUM / SNAP_DEN),
    SPAN_W'((UNITS_PER_TURN / 4) * SNAP_NUM / SNAP_DEN),
    SPAN_W'((UNITS_PER_TURN / 5) * SNAP_NUM / SNAP_DEN),
    SPAN_W'((UNITS_PER_TURN / 6) * SNAP_NUM / SNAP_DEN),
    SPAN_W'((UNITS_PER_TURN / 7) * SNAP_NUM / SNAP_DEN),
    SPAN_W'((UNITS_PER_TURN / 8) * SNAP_NUM / SNAP_DEN),
    SPAN_W'((UNITS_PER_TURN / 9) * SNAP_NUM / SNAP_DEN),
    SPAN_W'((UNITS_PER_TURN / 10) * SNAP_NUM / SNAP_DEN),
    SPAN_W'((UNITS_PER_TURN / 11) * SNAP_NUM / SNAP_DEN),
    SPAN_W'((UNITS_PER_TURN / 12) * SNAP_NUM / SNAP_DEN),
    SPAN_W'((UNITS_PER_TURN / 12) * SNAP_NUM / SNAP_DEN),
    SPAN_W'((UNITS_PER_TURN / 12) * SNAP_NUM / SNAP_DEN),
    SPAN_W'((UNITS_PER_TURN / 12) * SNAP_NUM / SNAP_DEN)
  };

  localparam logic [DEAD_W-1:0] DEAD_LUT [16] = '{
    DEAD_W'((0 * UNITS_PER_TURN) / DEG_PER_TURN),
    DEAD_W'((1 * UNITS_PER_TURN) / DEG_PER_TURN),
    DEAD_W'((2 * UNITS_PER_TURN) / DEG_PER_TURN),
    DEAD_W'((3 * UNITS_PER_TURN) / DEG_PER_TURN),
    DEAD_W'((4 * UNITS_PER_TURN) / DEG_PER_TURN),
    DEAD_W'((5 * UNITS_PER_TURN) / DEG_PER_TURN),
    DEAD_W'((6 * UNITS_PER_TURN) / DEG_PER_TURN),
    DEAD_W'((7 * UNITS_PER_TURN) / DEG_PER_TURN),
    DEAD_W'((8 * UNITS_PER_TURN) / DEG_PER_TURN),
    DEAD_W'((9 * UNITS_PER_TURN) / DEG_PER_TURN),
    DEAD_W'((10 * UNITS_PER_TURN) / DEG_PER_TURN),
    DEAD_W'((11 * UNITS_PER_TURN) / DEG_PER_TURN),
    DEAD_W'((12 * UNITS_PER_TURN) / DEG_PER_TURN),
    DEAD_W'((13 * UNITS_PER_TURN) / DEG_PER_TURN),
    DEAD_W'((14 * UNITS_PER_TURN) / DEG_PER_TURN),
    DEAD_W'((15 * UNITS_PER_TURN) / DEG_PER_TURN)
  };

  logic [DCOUNT_W-1:0]   detent_count;
  logic [GAIN_W-1:0]     gain;
  logic [LIMIT_W-1:0]    drive_limit;
  logic [DEAD_DEG_W-1:0] dead_zone_deg;
  logic [SCALED_W-1:0]   limit_scaled;

  logic [DCOUNT_W-1:0] dcount_sat;
  logic [SCALED_W-1:0] limit_plus;

  always_comb begin
    dcount_sat = data[DCOUNT_W-1:0];
    if (data[DCOUNT_W-1:0] < DCOUNT_W'(DCOUNT_MIN)) begin
      dcount_sat = DCOUNT_W'(DCOUNT_MIN);
    end else if (data[DCOUNT_W-1:0] > DCOUNT_W'(DCOUNT_MAX)) begin
      dcount_sat = DCOUNT_W'(DCOUNT_MAX);
    end
    limit_plus = SCALED_W'(data[LIMIT_W-1:0]) + SCALED_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      detent_count  <= DCOUNT_W'(DCOUNT_RESET);
      gain          <= GAIN_W'(GAIN_RESET);
      drive_limit   <= LIMIT_W'(LIMIT_RESET);
      dead_zone_deg <= DEAD_DEG_W'(DEAD_DEG_RESET);
      limit_scaled  <= SCALED_W'((LIMIT_RESET + 1) * DIV_BASE);
    end else if (we) begin
      unique case (cfg_index_t'(index))
        CFG_DETENT_COUNT: detent_count <= dcount_sat;
        CFG_GAIN:         gain <= data[GAIN_W-1:0];
        CFG_DRIVE_LIMIT: begin
          drive_limit  <= data[LIMIT_W-1:0];
          // first magnitude whose thousandths quotient passes the limit
          limit_scaled <= SCALED_W'(limit_plus * SCALED_W'(DIV_BASE));
        end
        CFG_DEAD_ZONE:    dead_zone_deg <= data[DEAD_DEG_W-1:0];
        default:          ;
      endcase
    end
  end

  always_comb begin
    cfg.span         = SPAN_LUT[detent_count];
    cfg.snap         = SNAP_LUT[detent_count];
    cfg.dead         = DEAD_LUT[dead_zone_deg];
    cfg.gain         = gain;
    cfg.limit        = drive_limit;
    cfg.limit_scaled = limit_scaled;
  end

endmodule

/* rtl/core/hdc_track.sv */
// detent tracking stage: centre, index and lockout state, error and dead zone
module hdc_track import hdc_pkg::*; #(
  parameter int LOCKOUT_TICKS = 40
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  sample_t in_item,
  input  cfg_t    cfg,
  output logic    out_valid,
  input  logic    out_ready,
  output track_t  out_item
);

  logic [CENTRE_W-1:0] centre_angle;
  logic [INDEX_W-1:0]  index_count;
  logic [LOCK_W-1:0]   lockout_ticks;

  logic [CENTRE_W-1:0] centre_angle_next;
  logic [INDEX_W-1:0]  index_count_next;
  logic [LOCK_W-1:0]   lockout_ticks_next;

  logic signed [ERR_W-1:0] angle_x, centre_x, span_x, snap_x, err, err_adj;
  logic                    snap_up, snap_dn, err_pos, fire;
  logic [MAG_W-1:0]        mag, mag_dz;

  assign in_ready = !out_valid || out_ready;
  assign fire     = in_valid && in_ready;

  always_comb begin
    angle_x  = {{(ERR_W - ANGLE_W){in_item.angle[ANGLE_W-1]}}, in_item.angle};
    centre_x = {{(ERR_W - CENTRE_W){centre_angle[CENTRE_W-1]}}, centre_angle};
    span_x   = ERR_W'(cfg.span);
    snap_x   = ERR_W'(cfg.snap);
    err      = angle_x - centre_x;
    snap_up  = (lockout_ticks == '0) && (err > snap_x);
    snap_dn  = (lockout_ticks == '0) && (err < -snap_x);

    centre_angle_next  = centre_angle;
    index_count_next   = index_count;
    lockout_ticks_next = lockout_ticks;
    err_adj            = err;
    priority if (in_item.capture) begin
      centre_angle_next  = {{(CENTRE_W - ANGLE_W){in_item.angle[ANGLE_W-1]}}, in_item.angle};
      index_count_next   = '0;
      lockout_ticks_next = '0;
    end else if (lockout_ticks != '0) begin
      lockout_ticks_next = lockout_ticks - LOCK_W'(1);
    end else if (snap_up) begin
      centre_angle_next  = centre_angle + CENTRE_W'(cfg.span);
      err_adj            = err - span_x;
      index_count_next   = index_count - INDEX_W'(1);
      lockout_ticks_next = LOCK_W'(LOCKOUT_TICKS);
    end else if (snap_dn) begin
      centre_angle_next  = centre_angle - CENTRE_W'(cfg.span);
      err_adj            = err + span_x;
      index_count_next   = index_count + INDEX_W'(1);
      lockout_ticks_next = LOCK_W'(LOCKOUT_TICKS);
    end else begin
      // error inside the snap window, state holds
    end

    // dead zone on the magnitude, drive opposes the error
    err_pos = !err_adj[ERR_W-1] && (err_adj != '0);
    mag     = err_adj[ERR_W-1] ? MAG_W'(-err_adj) : MAG_W'(err_adj);
    mag_dz  = (mag > MAG_W'(cfg.dead)) ? (mag - MAG_W'(cfg.dead)) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      centre_angle  <= '0;
      index_count   <= '0;
      lockout_ticks <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (fire) begin
        centre_angle  <= centre_angle_next;
        index_count   <= index_count_next;
        lockout_ticks <= lockout_ticks_next;
      end
      if (in_ready) begin
        out_valid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_item.capture <= in_item.capture;
      out_item.neg     <= err_pos;
      out_item.mag     <= mag_dz;
      out_item.index   <= index_count_next;
    end
  end

  a_lockout_bound: assert property (@(posedge clk) disable iff (rst)
    lockout_ticks <= LOCK_W'(LOCKOUT_TICKS))
    else $error("lockout counter above its restart value");

  a_snap_moves_index: assert property (@(posedge clk) disable iff (rst)
    (fire && !in_item.capture && lockout_ticks == '0 && lockout_ticks_next != '0) |=>
    (index_count == $past(index_count) + INDEX_W'(1) ||
     index_count == $past(index_count) - INDEX_W'(1)))
    else $error("snap without a one-step index move");

  a_capture_clears: assert property (@(posedge clk) disable iff (rst)
    (fire && in_item.capture) |=> (index_count == '0 && lockout_ticks == '0))
    else $error("capture left index or lockout set");

endmodule

/* rtl/core/hdc_drive.sv */
// drive path: gain product, thousandths divide with clamp, two-sample average
module hdc_drive import hdc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  track_t             in_item,
  input  cfg_t               cfg,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [DRIVE_W-1:0] drive,
  output logic [INDEX_W-1:0] detent_index
);

  localparam int RECIP_W = SCALED_W + DIV_MULT_W;

  // product stage
  logic               c_valid, c_capture, c_neg;
  logic [PROD_W-1:0]  c_prod;
  logic [INDEX_W-1:0] c_index;
  // quotient stage
  logic               d_valid, d_capture, d_neg;
  logic [LIMIT_W-1:0] d_q;
  logic [INDEX_W-1:0] d_index;

  logic                      adv_c, adv_d, adv_e;
  logic                      sat;
  logic [RECIP_W-1:0]        recip;
  logic [LIMIT_W-1:0]        q;
  logic signed [DRIVE_W-1:0] uq;
  logic signed [DRIVE_W:0]   sum, sum_rnd;

  assign adv_e    = !out_valid || out_ready;
  assign adv_d    = !d_valid || adv_e;
  assign adv_c    = !c_valid || adv_d;
  assign in_ready = adv_c;

  always_comb begin
    // below limit_scaled the magnitude fits the reciprocal multiplier
    sat   = c_prod >= PROD_W'(cfg.limit_scaled);
    recip = RECIP_W'(c_prod[SCALED_W-1:0]) * RECIP_W'(DIV_MULT);
    q     = sat ? cfg.limit : recip[DIV_SHIFT +: LIMIT_W];

    uq      = d_neg ? -$signed(DRIVE_W'(d_q)) : $signed(DRIVE_W'(d_q));
    sum     = $signed({drive[DRIVE_W-1], drive}) + $signed({uq[DRIVE_W-1], uq});
    // halve toward zero
    sum_rnd = sum + $signed((DRIVE_W + 1)'(sum[DRIVE_W]));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid   <= 1'b0;
      d_valid   <= 1'b0;
      out_valid <= 1'b0;
      drive     <= '0;
    end else begin
      if (adv_c) c_valid <= in_valid;
      if (adv_d) d_valid <= c_valid;
      if (adv_e) out_valid <= d_valid;
      // drive register doubles as the previous sample of the average
      if (adv_e && d_valid) begin
        drive <= d_capture ? '0 : sum_rnd[DRIVE_W:1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv_c && in_valid) begin
      c_capture <= in_item.capture;
      c_neg     <= in_item.neg;
      c_prod    <= PROD_W'(in_item.mag) * PROD_W'(cfg.gain);
      c_index   <= in_item.index;
    end
    if (adv_d && c_valid) begin
      d_capture <= c_capture;
      d_neg     <= c_neg;
      d_q       <= q;
      d_index   <= c_index;
    end
    if (adv_e && d_valid) begin
      detent_index <= d_index;
    end
  end

  a_quotient_clamped: assert property (@(posedge clk) disable iff (rst)
    d_valid |-> (d_q <= cfg.limit))
    else $error("clamped quotient above drive limit");

  a_capture_zero: assert property (@(posedge clk) disable iff (rst)
    (adv_e && d_valid && d_capture) |=> (drive == '0))
    else $error("capture did not clear the drive");

endmodule

/* rtl/core/haptic_detent_controller_top.sv */
// top level of the haptic detent controller
// Haptic detent controller. Each slave-side transaction carries a rotor angle
// in milliradians (tdata) and an opcode (tuser): opcode 1 captures the detent
// centre at that angle and returns zero drive and index zero, opcode 0 runs one
// control tick and returns the averaged torque drive and the signed detent
// index on the master side. The block sustains one transaction per clock
// while the master side does not stall; the path from the accepting edge,
// which loads the input register, to the result on the master side runs
// through the tracking stage, gain product, thousandths divide and clamp,
// and output register. The rate is set by the centre/index/lockout update
// in the tracking stage and by the drive average fed back from the output
// register, each of which closes through a single register. Stalls on the
// master side fill the internal stages first, so new transactions keep
// being taken while a result waits. Configuration writes take effect on
// the next cycle and are meant to be issued only while the block is idle;
// detent count writes saturate to 3..12. No clearing pass follows reset.
module haptic_detent_controller_top import hdc_pkg::*; #(
  parameter int LOCKOUT_TICKS  = 40,
  parameter int UNITS_PER_TURN = 6283
) (
  input  logic                   clk,
  input  logic                   rst,
  // configuration write port
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  // slave side
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [ANGLE_W-1:0]     s_axis_tdata,   // angle
  input  logic [0:0]             s_axis_tuser,   // opcode
  // master side
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [DRIVE_W+INDEX_W-1:0] m_axis_tdata // drive, detent_index
);

  cfg_t    cfg;
  sample_t in_item;
  logic    in_valid;
  track_t  trk_item;
  logic    trk_ready, trk_valid, drv_ready;

  logic [DRIVE_W-1:0] drive;
  logic [INDEX_W-1:0] detent_index;

  hdc_cfg #(
    .UNITS_PER_TURN(UNITS_PER_TURN)
  ) u_cfg (
    .clk  (clk),
    .rst  (rst),
    .we   (cfg_we),
    .index(cfg_index),
    .data (cfg_data),
    .cfg  (cfg)
  );

  // input register, refilled in the same cycle it drains
  assign s_axis_tready = !in_valid || trk_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item.capture <= s_axis_tuser[0];
      in_item.angle   <= s_axis_tdata;
    end
  end

  hdc_track #(
    .LOCKOUT_TICKS(LOCKOUT_TICKS)
  ) u_track (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (trk_ready),
    .in_item  (in_item),
    .cfg      (cfg),
    .out_valid(trk_valid),
    .out_ready(drv_ready),
    .out_item (trk_item)
  );

  hdc_drive u_drive (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (trk_valid),
    .in_ready    (drv_ready),
    .in_item     (trk_item),
    .cfg         (cfg),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .drive       (drive),
    .detent_index(detent_index)
  );

  assign m_axis_tdata = {detent_index, drive};

endmodule

/* tb/sv/haptic_detent_controller_top_tb.sv */
// self-checking stream testbench for the haptic detent controller top level
`timescale 1ns / 100ps

module haptic_detent_controller_top_tb;
  import hdc_pkg::*;

  // same parameter values are handed to the block below
  localparam int LOCKOUT_TICKS  = 40;
  localparam int UNITS_PER_TURN = 6283;

  localparam logic OP_STEP    = 1'b0;
  localparam logic OP_CAPTURE = 1'b1;

  localparam longint ANGLE_MAX = 64'sd8388607;
  localparam longint ANGLE_MIN = -64'sd8388608;

  // bound on a correct run of roughly 1250 transactions, each with its longest source gap and sink stall
  localparam int CYCLE_LIMIT = 800000;

  typedef struct {
    logic               op;
    logic [ANGLE_W-1:0] angle;
  } tick_t;

  typedef struct {
    logic [DRIVE_W-1:0] drive;
    logic [INDEX_W-1:0] index;
  } drive_cmd_t;

  logic                       clk = 1'b0;
  logic                       rst;
  logic                       cfg_we;
  cfg_index_t                 cfg_index;
  logic [CFG_DATA_W-1:0]      cfg_data;
  logic                       s_axis_tvalid;
  logic                       s_axis_tready;
  logic [ANGLE_W-1:0]         s_axis_tdata;   // angle
  logic [0:0]                 s_axis_tuser;   // opcode
  logic                       m_axis_tvalid;
  logic                       m_axis_tready;
  logic [DRIVE_W+INDEX_W-1:0] m_axis_tdata;   // drive, detent_index

  haptic_detent_controller_top #(
    .LOCKOUT_TICKS (LOCKOUT_TICKS),
    .UNITS_PER_TURN(UNITS_PER_TURN)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // predictor: configuration and detent tracking state
  // ---------------------------------------------------------------------------
  longint           reg_dcount   = DCOUNT_RESET;
  longint           reg_gain     = GAIN_RESET;
  longint           reg_limit    = LIMIT_RESET;
  longint           reg_dead_deg = DEAD_DEG_RESET;

  longint           ctr_centre     = 0;
  logic [INDEX_W-1:0] ctr_index    = '0;
  int               ctr_lockout    = 0;
  longint           ctr_prev_drive = 0;

  tick_t            pending_ticks[$];
  drive_cmd_t       expected_cmds[$];

  int               fail_count  = 0;
  int               cycle_count = 0;

  // driver / sink bookkeeping
  logic             in_fire = 1'b0;
  tick_t            cur_tick;
  int               src_gap    = 0;
  int               src_calm   = 0;
  int               sink_stall = 0;
  int               sink_calm  = 0;

  // centre register is 26 bits wide and wraps
  function automatic longint wrap_centre(input longint v);
    logic [CENTRE_W-1:0] t;
    t = v[CENTRE_W-1:0];
    return longint'($signed(t));
  endfunction

  // one control tick: updates the tracking state, returns the command it emits
  function automatic drive_cmd_t track_detent(input tick_t t);
    drive_cmd_t r;
    longint     ang, span, snap, dead, err, in_err, uq;
    ang = longint'($signed(t.angle));
    if (t.op == OP_CAPTURE) begin
      // capture re-centres and clears everything, output reads zero
      ctr_centre     = wrap_centre(ang);
      ctr_index      = '0;
      ctr_lockout    = 0;
      ctr_prev_drive = 0;
      r.drive        = '0;
      r.index        = '0;
      return r;
    end
    span = UNITS_PER_TURN / reg_dcount;
    snap = (span * SNAP_NUM) / SNAP_DEN;
    dead = (reg_dead_deg * UNITS_PER_TURN) / DEG_PER_TURN;
    err  = ang - ctr_centre;
    // snap test is skipped while the lockout counts down
    if (ctr_lockout > 0) begin
      ctr_lockout--;
    end else if (err > snap) begin
      ctr_centre  = wrap_centre(ctr_centre + span);
      err         = err - span;
      ctr_index   = ctr_index - 1'b1;
      ctr_lockout = LOCKOUT_TICKS & 8'hFF;
    end else if (err < -snap) begin
      ctr_centre  = wrap_centre(ctr_centre - span);
      err         = err + span;
      ctr_index   = ctr_index + 1'b1;
      ctr_lockout = LOCKOUT_TICKS & 8'hFF;
    end
    if (err <= dead && err >= -dead) begin
      in_err = 0;
    end else if (err > 0) begin
      in_err = -(err - dead);
    end else begin
      in_err = -(err + dead);
    end
    // full-width product, truncating divide, then clamp and two-sample average
    uq = (reg_gain * in_err) / DIV_BASE;
    if (uq > reg_limit) uq = reg_limit;
    if (uq < -reg_limit) uq = -reg_limit;
    uq             = (ctr_prev_drive + uq) / 2;
    ctr_prev_drive = uq;
    r.drive        = uq[DRIVE_W-1:0];
    r.index        = ctr_index;
    return r;
  endfunction

  // idle lengths: mostly none or short, a few long, with runs of no idling
  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // ---------------------------------------------------------------------------
  // source driver: presents pending ticks at the falling edge
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : tick_driver
    logic nv;
    if (!rst) begin
      nv = s_axis_tvalid;
      if (in_fire) begin
        // transaction taken at the last rising edge: predict it now
        expected_cmds.push_back(track_detent(cur_tick));
        nv      = 1'b0;
        src_gap = pick_gap(src_calm);
      end
      if (!nv) begin
        if (src_gap > 0) begin
          src_gap--;
        end else if (pending_ticks.size() > 0) begin
          cur_tick     = pending_ticks.pop_front();
          nv           = 1'b1;
          s_axis_tdata <= cur_tick.angle;
          s_axis_tuser <= cur_tick.op;
        end
      end
      s_axis_tvalid <= nv;
    end
  end

  // result sink: random backpressure
  always @(negedge clk) begin : cmd_sink
    logic rdy;
    if (sink_stall > 0) begin
      sink_stall--;
      rdy = 1'b0;
    end else begin
      rdy        = 1'b1;
      sink_stall = pick_gap(sink_calm);
    end
    m_axis_tready <= rdy;
  end

  // ---------------------------------------------------------------------------
  // monitor: samples both handshakes at the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : cmd_monitor
    drive_cmd_t         want;
    logic [DRIVE_W-1:0] got_drive;
    logic [INDEX_W-1:0] got_index;
    if (rst) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= s_axis_tvalid && s_axis_tready;
      if (m_axis_tvalid && m_axis_tready) begin
        got_drive = m_axis_tdata[DRIVE_W-1:0];
        got_index = m_axis_tdata[DRIVE_W +: INDEX_W];
        if (expected_cmds.size() == 0) begin
          $display("%0t: unexpected result, drive %0d index %0d", $time,
                   $signed(got_drive), $signed(got_index));
          fail_count++;
        end else begin
          want = expected_cmds.pop_front();
          if (got_drive !== want.drive) begin
            $display("%0t: drive mismatch, expected %0d actual %0d", $time,
                     $signed(want.drive), $signed(got_drive));
            fail_count++;
          end
          if (got_index !== want.index) begin
            $display("%0t: detent_index mismatch, expected %0d actual %0d", $time,
                     $signed(want.index), $signed(got_index));
            fail_count++;
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void queue_tick(input logic op, input longint pos);
    tick_t t;
    t.op    = op;
    t.angle = pos[ANGLE_W-1:0];
    pending_ticks.push_back(t);
  endfunction

  // starting angle: mostly near zero, some at the ends of the angle range
  function automatic longint pick_base();
    int                 r;
    logic [ANGLE_W-1:0] raw;
    r   = $urandom_range(0, 99);
    raw = ANGLE_W'($urandom);
    if (r < 60) return longint'($urandom_range(0, 60000)) - 30000;
    if (r < 75) return ANGLE_MAX - longint'($urandom_range(0, 3000));
    if (r < 90) return ANGLE_MIN + longint'($urandom_range(0, 3000));
    return longint'($signed(raw));
  endfunction

  // mostly capture followed by a smooth rotor trajectory, some noise and
  // sequences that never capture or jump about
  task automatic fill_ticks(input int quota);
    int     made, kind, len, k;
    longint pos, vel;
    made = 0;
    while (made < quota) begin
      kind = $urandom_range(0, 99);
      if (kind < 75) begin
        pos = pick_base();
        queue_tick(OP_CAPTURE, pos);
        made++;
        vel = longint'($urandom_range(0, 160)) - 80;
        len = $urandom_range(20, 120);
        for (k = 0; k < len; k++) begin
          if ($urandom_range(0, 9) == 0) vel = longint'($urandom_range(0, 200)) - 100;
          pos = pos + vel + longint'($urandom_range(0, 6)) - 3;
          if (pos > ANGLE_MAX) pos = ANGLE_MAX;
          if (pos < ANGLE_MIN) pos = ANGLE_MIN;
          queue_tick(OP_STEP, pos);
          made++;
        end
      end else if (kind < 90) begin
        // full-range noise, either opcode
        len = $urandom_range(1, 10);
        for (k = 0; k < len; k++) begin
          queue_tick(logic'($urandom_range(0, 1)), longint'($urandom));
          made++;
        end
      end else begin
        // no capture, occasional wild jumps
        pos = pick_base();
        len = $urandom_range(5, 40);
        for (k = 0; k < len; k++) begin
          if ($urandom_range(0, 7) == 0) pos = pick_base();
          else pos = pos + longint'($urandom_range(0, 400)) - 200;
          if (pos > ANGLE_MAX) pos = ANGLE_MAX;
          if (pos < ANGLE_MIN) pos = ANGLE_MIN;
          queue_tick(OP_STEP, pos);
          made++;
        end
      end
    end
  endtask

  // block is idle once every tick is taken and every command has come back
  task automatic wait_idle();
    do begin
      @(posedge clk);
      #1;
    end while (pending_ticks.size() != 0 || s_axis_tvalid || expected_cmds.size() != 0);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      CFG_DETENT_COUNT: begin
        // detent count saturates into 3..12
        reg_dcount = longint'(val[DCOUNT_W-1:0]);
        if (reg_dcount < DCOUNT_MIN) reg_dcount = DCOUNT_MIN;
        if (reg_dcount > DCOUNT_MAX) reg_dcount = DCOUNT_MAX;
      end
      CFG_GAIN:        reg_gain     = longint'(val[GAIN_W-1:0]);
      CFG_DRIVE_LIMIT: reg_limit    = longint'(val[LIMIT_W-1:0]);
      CFG_DEAD_ZONE:   reg_dead_deg = longint'(val[DEAD_DEG_W-1:0]);
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_setting(input int dc, input int g, input int lim, input int dz);
    write_reg(CFG_DETENT_COUNT, CFG_DATA_W'(dc));
    write_reg(CFG_GAIN, CFG_DATA_W'(g));
    write_reg(CFG_DRIVE_LIMIT, CFG_DATA_W'(lim));
    write_reg(CFG_DEAD_ZONE, CFG_DATA_W'(dz));
    // queue the next phase away from the driver's falling edge
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin : run_test
    int ph;
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = CFG_DETENT_COUNT;
    cfg_data      = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    m_axis_tready = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part on reset settings: width 523, snap 339, dead zone 34
    queue_tick(OP_STEP, 0);
    queue_tick(OP_STEP, ANGLE_MAX);        // huge error, snap and saturation
    queue_tick(OP_STEP, ANGLE_MIN);        // lockout running, negative saturation
    queue_tick(OP_CAPTURE, ANGLE_MAX);
    queue_tick(OP_STEP, ANGLE_MAX);
    queue_tick(OP_STEP, ANGLE_MIN);
    queue_tick(OP_CAPTURE, ANGLE_MIN);
    queue_tick(OP_STEP, ANGLE_MIN);
    queue_tick(OP_STEP, ANGLE_MAX);
    queue_tick(OP_CAPTURE, 0);
    queue_tick(OP_STEP, 34);               // dead zone edges
    queue_tick(OP_STEP, 35);
    queue_tick(OP_STEP, -34);
    queue_tick(OP_STEP, -35);
    queue_tick(OP_STEP, 339);              // right at the snap threshold
    queue_tick(OP_STEP, 340);              // just beyond: snap, lockout starts
    queue_tick(OP_STEP, -600);             // lockout suppresses snap
    queue_tick(OP_CAPTURE, 0);
    queue_tick(OP_STEP, -340);             // snap the other way
    queue_tick(OP_STEP, 0);
    fill_ticks(150);
    wait_idle();

    // extremes: detent count below range, largest gain, limit and dead zone
    apply_setting(0, 65535, 32767, 15);
    fill_ticks(150);
    wait_idle();

    // detent count above range, everything else zero
    apply_setting(15, 0, 0, 0);
    fill_ticks(150);
    wait_idle();

    apply_setting(3, 1, 1, 1);
    fill_ticks(150);
    wait_idle();

    apply_setting(12, 1000, 500, 5);
    fill_ticks(150);
    wait_idle();

    // random settings, gain kept mostly in a useful range
    for (ph = 0; ph < 3; ph++) begin
      apply_setting($urandom_range(0, 15),
                    ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                : $urandom_range(0, 8000),
                    $urandom_range(0, 32767), $urandom_range(0, 15));
      fill_ticks(150);
      wait_idle();
    end

    // let any stray result show up before the verdict
    repeat (10) @(negedge clk);
    if (fail_count == 0 && expected_cmds.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
